// ----- src/mmpcc_pkg.sv -----
`default_nettype none

package mmpcc_pkg;

  // widest sample precision that is honoured
  localparam int unsigned SAMPLE_BITS = 16;

  // width of the cmyk inverted terms, 255*2^16 - x*S
  localparam int unsigned KW = 44;

  localparam logic [2:0] MODE_RGB   = 3'd0;
  localparam logic [2:0] MODE_RGBA  = 3'd1;
  localparam logic [2:0] MODE_GRAY  = 3'd2;
  localparam logic [2:0] MODE_GRAYA = 3'd3;
  localparam logic [2:0] MODE_SYCC  = 3'd4;
  localparam logic [2:0] MODE_EYCC  = 3'd5;
  localparam logic [2:0] MODE_CMYK  = 3'd6;

  localparam logic [2:0] CFG_COLOR_MODE    = 3'd0;
  localparam logic [2:0] CFG_PRECISION_A   = 3'd1;
  localparam logic [2:0] CFG_PRECISION_B   = 3'd2;
  localparam logic [2:0] CFG_PRECISION_C   = 3'd3;
  localparam logic [2:0] CFG_PRECISION_D   = 3'd4;
  localparam logic [2:0] CFG_CHROMA_SIGNED = 3'd5;
  localparam logic [2:0] CFG_ALPHA_LEADING = 3'd6;

  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
  } mmpcc_en_t;

  function automatic logic [4:0] eff_prec(input logic [4:0] p);
    logic [4:0] r;
    r = p;
    if (p == 5'd0) r = 5'd1;
    else if (p > 5'(SAMPLE_BITS)) r = 5'(SAMPLE_BITS);
    return r;
  endfunction

  // ceil(255*2^16 / (2^p - 1))
  function automatic logic [23:0] scale_of(input logic [4:0] p);
    logic [23:0] s;
    case (p)
      5'd1:    s = 24'd16711680;
      5'd2:    s = 24'd5570560;
      5'd3:    s = 24'd2387383;
      5'd4:    s = 24'd1114112;
      5'd5:    s = 24'd539087;
      5'd6:    s = 24'd265265;
      5'd7:    s = 24'd131589;
      5'd8:    s = 24'd65536;
      5'd9:    s = 24'd32704;
      5'd10:   s = 24'd16336;
      5'd11:   s = 24'd8164;
      5'd12:   s = 24'd4081;
      5'd13:   s = 24'd2041;
      5'd14:   s = 24'd1021;
      5'd15:   s = 24'd511;
      default: s = 24'd256;
    endcase
    return s;
  endfunction

  function automatic logic signed [17:0] half_of(input logic [4:0] p);
    return 18'sd1 <<< (p - 5'd1);
  endfunction

  // q.16 value truncated and clamped to 0..255
  function automatic logic [7:0] fin16(input logic signed [42:0] v);
    logic [7:0] r;
    if (v[42]) r = 8'd0;
    else if (|v[41:24]) r = 8'd255;
    else r = v[23:16];
    return r;
  endfunction

  // q.32 value truncated and clamped to 0..255
  function automatic logic [7:0] fin32(input logic signed [61:0] v);
    logic [7:0] r;
    if (v[61]) r = 8'd0;
    else if (|v[60:40]) r = 8'd255;
    else r = v[39:32];
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/mmpcc_cmyk.sv -----
`default_nettype none

module mmpcc_cmyk (
  input  wire logic                            clk_i,
  input  wire mmpcc_pkg::mmpcc_en_t            en_i,
  input  wire logic signed [mmpcc_pkg::KW-1:0] x_i,
  input  wire logic signed [mmpcc_pkg::KW-1:0] k_i,
  output logic [7:0]                           chan_o
);

  localparam int unsigned KW_TOP = mmpcc_pkg::KW - 1;

  logic        zero4_d, sat4_d;
  logic [41:0] ax, ak;
  logic [23:0] small4_d;
  logic [41:0] big4_d;

  logic        zero4_q, sat4_q;
  logic [23:0] small4_q;
  logic [41:0] big4_q;

  logic        zero5_q, sat5_q;
  logic [44:0] ph5_q, pl5_q;
  logic [44:0] ph5_d, pl5_d;

  logic        zero6_q, sat6_q, sat6_d;
  logic [15:0] q6_q;
  logic [65:0] prod;
  logic [33:0] qfull;

  logic [23:0] est;
  logic [7:0]  e;
  logic [16:0] rem;

  always_comb begin
    ax = x_i[KW_TOP] ? 42'(-x_i) : 42'(x_i);
    ak = k_i[KW_TOP] ? 42'(-k_i) : 42'(k_i);
    zero4_d = (x_i == '0) || (k_i == '0) || (x_i[KW_TOP] != k_i[KW_TOP]);
    // both at or above 2^24: the product is past 255*255*2^32
    sat4_d = (|ax[41:24]) && (|ak[41:24]);
    if (|ax[41:24]) begin
      small4_d = ak[23:0];
      big4_d   = ax;
    end else begin
      small4_d = ax[23:0];
      big4_d   = ak;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      zero4_q  <= zero4_d;
      sat4_q   <= sat4_d;
      small4_q <= small4_d;
      big4_q   <= big4_d;
    end
  end

  assign ph5_d = 45'(small4_q) * 45'(big4_q[41:21]);
  assign pl5_d = 45'(small4_q) * 45'(big4_q[20:0]);

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      zero5_q <= zero4_q;
      sat5_q  <= sat4_q;
      ph5_q   <= ph5_d;
      pl5_q   <= pl5_d;
    end
  end

  assign prod   = (66'(ph5_q) << 21) + 66'(pl5_q);
  assign qfull  = prod[65:32];
  assign sat6_d = sat5_q || (qfull >= 34'd65025);

  always_ff @(posedge clk_i) begin
    if (en_i.s6) begin
      zero6_q <= zero5_q;
      sat6_q  <= sat6_d;
      q6_q    <= qfull[15:0];
    end
  end

  // divide by 255: estimate with 257/65536, at most one short
  always_comb begin
    est = 24'(q6_q) * 24'd257;
    e   = est[23:16];
    rem = 17'(q6_q) - 17'(e) * 17'd255;
    if (rem >= 17'd255) e = e + 8'd1;
    if (zero6_q) chan_o = 8'd0;
    else if (sat6_q) chan_o = 8'd255;
    else chan_o = e;
  end

endmodule

`default_nettype wire

// ----- src/multi_mode_pixel_color_converter_core.sv -----
`default_nettype none

// pixel colour converter: four component samples in, 8-bit r, g, b, a out
// input channel: in_valid_i / in_ready_o with sample_a_i .. sample_d_i
// output channel: out_valid_o / out_ready_i with red_o, green_o, blue_o,
// alpha_o; one result transaction for every input transaction, in order
// config channel: cfg_valid_i / cfg_ready_o with cfg_index_i, cfg_data_i;
// always ready, write only while no pixel is in flight
// one pixel per cycle is taken and given while the receiver is ready, in a
// seven stage pipeline whose deepest step is a split 24x21 multiply in the
// cmyk channel path
// each stage holds its data while the stage after it is full and stalled,
// so a stalled receiver backs the pipeline up one stage at a time and
// in_ready_o drops only once every stage is full
// reset clears all valid bits and loads mode rgb, precisions 8,
// chroma signed mask 0 and alpha trailing
module multi_mode_pixel_color_converter_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [15:0]        sample_a_i,
  input  wire logic signed [16:0] sample_b_i,
  input  wire logic signed [16:0] sample_c_i,
  input  wire logic [15:0]        sample_d_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              red_o,
  output logic [7:0]              green_o,
  output logic [7:0]              blue_o,
  output logic [7:0]              alpha_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [7:0]         cfg_data_i
);

  // configuration
  logic [2:0] mode_q;
  logic [4:0] prec_a_q, prec_b_q, prec_c_q, prec_d_q;
  logic [1:0] mask_q;
  logic       lead_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= mmpcc_pkg::MODE_RGB;
      prec_a_q <= 5'd8;
      prec_b_q <= 5'd8;
      prec_c_q <= 5'd8;
      prec_d_q <= 5'd8;
      mask_q   <= 2'd0;
      lead_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mmpcc_pkg::CFG_COLOR_MODE:    mode_q   <= cfg_data_i[2:0];
        mmpcc_pkg::CFG_PRECISION_A:   prec_a_q <= cfg_data_i[4:0];
        mmpcc_pkg::CFG_PRECISION_B:   prec_b_q <= cfg_data_i[4:0];
        mmpcc_pkg::CFG_PRECISION_C:   prec_c_q <= cfg_data_i[4:0];
        mmpcc_pkg::CFG_PRECISION_D:   prec_d_q <= cfg_data_i[4:0];
        mmpcc_pkg::CFG_CHROMA_SIGNED: mask_q   <= cfg_data_i[1:0];
        mmpcc_pkg::CFG_ALPHA_LEADING: lead_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic en1, en2, en3, en4, en5, en6, en7;
  mmpcc_pkg::mmpcc_en_t cm_en;

  assign en7 = !v7_q || out_ready_i;
  assign en6 = !v6_q || en7;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;
  assign cm_en = '{s4: en4, s5: en5, s6: en6};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
    end
  end

  // stage 1: operands with chroma re-centred, per-sample scales
  logic [4:0]         pe_a, pe_b, pe_c, pe_d;
  logic signed [17:0] op_b_d, op_c_d;
  logic signed [17:0] op_a_q, op_b_q, op_c_q, op_d_q;
  logic [23:0]        sc_a_q, sc_b_q, sc_c_q, sc_d_q;
  logic [2:0]         mode1_q;
  logic               lead1_q;

  assign pe_a = mmpcc_pkg::eff_prec(prec_a_q);
  assign pe_b = mmpcc_pkg::eff_prec(prec_b_q);
  assign pe_c = mmpcc_pkg::eff_prec(prec_c_q);
  assign pe_d = mmpcc_pkg::eff_prec(prec_d_q);

  always_comb begin
    op_b_d = 18'(sample_b_i);
    op_c_d = 18'(sample_c_i);
    if (mode_q == mmpcc_pkg::MODE_SYCC) begin
      op_b_d = 18'(sample_b_i) - mmpcc_pkg::half_of(pe_b);
      op_c_d = 18'(sample_c_i) - mmpcc_pkg::half_of(pe_c);
    end else if (mode_q == mmpcc_pkg::MODE_EYCC) begin
      // eycc centres each chroma on the luma precision unless its mask bit is set
      if (!mask_q[0]) op_b_d = 18'(sample_b_i) - mmpcc_pkg::half_of(pe_a);
      if (!mask_q[1]) op_c_d = 18'(sample_c_i) - mmpcc_pkg::half_of(pe_a);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      op_a_q  <= $signed({2'b00, sample_a_i});
      op_b_q  <= op_b_d;
      op_c_q  <= op_c_d;
      op_d_q  <= $signed({2'b00, sample_d_i});
      sc_a_q  <= mmpcc_pkg::scale_of(pe_a);
      sc_b_q  <= mmpcc_pkg::scale_of(pe_b);
      sc_c_q  <= mmpcc_pkg::scale_of(pe_c);
      sc_d_q  <= mmpcc_pkg::scale_of(pe_d);
      mode1_q <= mode_q;
      lead1_q <= lead_q;
    end
  end

  // stage 2: scaled samples, eycc matrix rows in q.16
  logic signed [37:0] a38, b38, c38;
  logic signed [37:0] lr_d, lg_d, lb_d, lr_q, lg_q, lb_q;
  logic signed [42:0] p_a_q, p_b_q, p_c_q, p_d_q;
  logic [23:0]        sc2_a_q;
  logic [2:0]         mode2_q;
  logic               lead2_q;

  assign a38 = 38'(op_a_q);
  assign b38 = 38'(op_b_q);
  assign c38 = 38'(op_c_q);
  assign lr_d = (a38 <<< 16) - (b38 <<< 1) + c38 * 38'sd91881 + 38'sd32768;
  assign lg_d = a38 * 38'sd65556 - b38 * 38'sd22553 - c38 * 38'sd46800 + 38'sd32768;
  assign lb_d = a38 * 38'sd65524 + b38 * 38'sd116132 - c38 + 38'sd32768;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      p_a_q   <= 43'(op_a_q) * 43'($signed({1'b0, sc_a_q}));
      p_b_q   <= 43'(op_b_q) * 43'($signed({1'b0, sc_b_q}));
      p_c_q   <= 43'(op_c_q) * 43'($signed({1'b0, sc_c_q}));
      p_d_q   <= 43'(op_d_q) * 43'($signed({1'b0, sc_d_q}));
      lr_q    <= lr_d;
      lg_q    <= lg_d;
      lb_q    <= lb_d;
      sc2_a_q <= sc_a_q;
      mode2_q <= mode1_q;
      lead2_q <= lead1_q;
    end
  end

  // stage 3: direct modes finished, matrix products split in halves,
  // cmyk inverted terms
  logic [7:0]         fa, fb, fc, fd;
  logic [7:0]         dr_d, dg_d, db_d, da_d;
  logic [7:0]         dr_q, dg_q, db_q, da_q;
  logic signed [44:0] sa45;
  logic signed [39:0] yrh_q, yrl_q, ygbh_q, ygbl_q, ygrh_q, ygrl_q, ybh_q, ybl_q;
  logic signed [42:0] yf_q;
  logic signed [44:0] erh_q, erl_q, egh_q, egl_q, ebh_q, ebl_q;
  logic signed [mmpcc_pkg::KW-1:0] ka_q, kb_q, kc_q, kd_q;
  logic [2:0]         mode3_q;

  assign fa = mmpcc_pkg::fin16(p_a_q);
  assign fb = mmpcc_pkg::fin16(p_b_q);
  assign fc = mmpcc_pkg::fin16(p_c_q);
  assign fd = mmpcc_pkg::fin16(p_d_q);
  assign sa45 = 45'($signed({1'b0, sc2_a_q}));

  always_comb begin
    dr_d = 8'd0;
    dg_d = 8'd0;
    db_d = 8'd0;
    da_d = 8'd255;
    case (mode2_q)
      mmpcc_pkg::MODE_RGB: begin
        dr_d = fa;
        dg_d = fb;
        db_d = fc;
      end
      mmpcc_pkg::MODE_RGBA: begin
        if (lead2_q) begin
          da_d = fa;
          dr_d = fb;
          dg_d = fc;
          db_d = fd;
        end else begin
          dr_d = fa;
          dg_d = fb;
          db_d = fc;
          da_d = fd;
        end
      end
      mmpcc_pkg::MODE_GRAY: begin
        dr_d = fa;
        dg_d = fa;
        db_d = fa;
      end
      mmpcc_pkg::MODE_GRAYA: begin
        dr_d = lead2_q ? fb : fa;
        dg_d = dr_d;
        db_d = dr_d;
        da_d = lead2_q ? fa : fb;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      dr_q    <= dr_d;
      dg_q    <= dg_d;
      db_q    <= db_d;
      da_q    <= da_d;
      yf_q    <= p_a_q;
      yrh_q   <= 40'($signed(p_c_q[42:21])) * 40'sd91881;
      yrl_q   <= 40'($signed({1'b0, p_c_q[20:0]})) * 40'sd91881;
      ygbh_q  <= 40'($signed(p_b_q[42:21])) * 40'sd22544;
      ygbl_q  <= 40'($signed({1'b0, p_b_q[20:0]})) * 40'sd22544;
      ygrh_q  <= 40'($signed(p_c_q[42:21])) * 40'sd46793;
      ygrl_q  <= 40'($signed({1'b0, p_c_q[20:0]})) * 40'sd46793;
      ybh_q   <= 40'($signed(p_b_q[42:21])) * 40'sd116130;
      ybl_q   <= 40'($signed({1'b0, p_b_q[20:0]})) * 40'sd116130;
      erh_q   <= 45'($signed(lr_q[37:18])) * sa45;
      erl_q   <= 45'($signed({1'b0, lr_q[17:0]})) * sa45;
      egh_q   <= 45'($signed(lg_q[37:18])) * sa45;
      egl_q   <= 45'($signed({1'b0, lg_q[17:0]})) * sa45;
      ebh_q   <= 45'($signed(lb_q[37:18])) * sa45;
      ebl_q   <= 45'($signed({1'b0, lb_q[17:0]})) * sa45;
      ka_q    <= 44'sd16711680 - 44'(p_a_q);
      kb_q    <= 44'sd16711680 - 44'(p_b_q);
      kc_q    <= 44'sd16711680 - 44'(p_c_q);
      kd_q    <= 44'sd16711680 - 44'(p_d_q);
      mode3_q <= mode2_q;
    end
  end

  // stage 4: matrix sums in q.32 and mode select
  logic signed [61:0] yf62, sr, sg, sb, er, eg, eb;
  logic [7:0]         r4_d, g4_d, b4_d;
  logic [7:0]         r4_q, g4_q, b4_q, a4_q;
  logic [7:0]         r5_q, g5_q, b5_q, a5_q;
  logic [7:0]         r6_q, g6_q, b6_q, a6_q;
  logic [2:0]         mode4_q, mode5_q, mode6_q, mode7_q;

  assign yf62 = 62'(yf_q) <<< 16;
  assign sr = yf62 + (62'(yrh_q) <<< 21) + 62'(yrl_q);
  assign sg = yf62 - ((62'(ygbh_q) <<< 21) + 62'(ygbl_q)
                    + (62'(ygrh_q) <<< 21) + 62'(ygrl_q));
  assign sb = yf62 + (62'(ybh_q) <<< 21) + 62'(ybl_q);
  assign er = (62'(erh_q) <<< 18) + 62'(erl_q);
  assign eg = (62'(egh_q) <<< 18) + 62'(egl_q);
  assign eb = (62'(ebh_q) <<< 18) + 62'(ebl_q);

  always_comb begin
    r4_d = dr_q;
    g4_d = dg_q;
    b4_d = db_q;
    case (mode3_q)
      mmpcc_pkg::MODE_SYCC: begin
        r4_d = mmpcc_pkg::fin32(sr);
        g4_d = mmpcc_pkg::fin32(sg);
        b4_d = mmpcc_pkg::fin32(sb);
      end
      mmpcc_pkg::MODE_EYCC: begin
        r4_d = mmpcc_pkg::fin32(er);
        g4_d = mmpcc_pkg::fin32(eg);
        b4_d = mmpcc_pkg::fin32(eb);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      r4_q    <= r4_d;
      g4_q    <= g4_d;
      b4_q    <= b4_d;
      a4_q    <= da_q;
      mode4_q <= mode3_q;
    end
    if (en5) begin
      r5_q    <= r4_q;
      g5_q    <= g4_q;
      b5_q    <= b4_q;
      a5_q    <= a4_q;
      mode5_q <= mode4_q;
    end
    if (en6) begin
      r6_q    <= r5_q;
      g6_q    <= g5_q;
      b6_q    <= b5_q;
      a6_q    <= a5_q;
      mode6_q <= mode5_q;
    end
  end

  // stages 4 to 6 of the cmyk path, one unit per channel
  logic [7:0] cm_r, cm_g, cm_b;

  mmpcc_cmyk u_cmyk_r (.clk_i, .en_i(cm_en), .x_i(ka_q), .k_i(kd_q), .chan_o(cm_r));
  mmpcc_cmyk u_cmyk_g (.clk_i, .en_i(cm_en), .x_i(kb_q), .k_i(kd_q), .chan_o(cm_g));
  mmpcc_cmyk u_cmyk_b (.clk_i, .en_i(cm_en), .x_i(kc_q), .k_i(kd_q), .chan_o(cm_b));

  // stage 7: output register
  logic [7:0] red_q, green_q, blue_q, alpha_q;
  logic       is_cmyk6;

  assign is_cmyk6 = (mode6_q == mmpcc_pkg::MODE_CMYK);

  always_ff @(posedge clk_i) begin
    if (en7) begin
      red_q   <= is_cmyk6 ? cm_r : r6_q;
      green_q <= is_cmyk6 ? cm_g : g6_q;
      blue_q  <= is_cmyk6 ? cm_b : b6_q;
      alpha_q <= a6_q;
      mode7_q <= mode6_q;
    end
  end

  assign out_valid_o = v7_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_o     = alpha_q;

`ifndef ASSERT_OFF
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && v4_q && v5_q && v6_q && v7_q && !out_ready_i)
      |-> !in_ready_o)
    else $error("pipeline accepts a transaction while every stage is stalled");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted transaction missing from first stage");

  a_out_from_upstream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v7_q) |-> $past(v6_q))
    else $error("output valid without an item in the previous stage");

  a_alpha_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (mode7_q == mmpcc_pkg::MODE_SYCC || mode7_q == mmpcc_pkg::MODE_EYCC
      || mode7_q == mmpcc_pkg::MODE_CMYK)) |-> (alpha_o == 8'd255))
    else $error("alpha not opaque in a mode without alpha");
`endif

endmodule

`default_nettype wire

// ----- bench/multi_mode_pixel_color_converter_core_test.sv -----
`timescale 1ns / 1ps

module multi_mode_pixel_color_converter_core_test;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  class pixel_scoreboard;
    logic [2:0] mode;
    logic [4:0] prec [4];
    logic [1:0] signed_mask;
    logic       lead;
    pixel_t     pending [$];
    int         mismatches;

    function new();
      mode = mmpcc_pkg::MODE_RGB;
      foreach (prec[i]) prec[i] = 5'd8;
      signed_mask = 2'd0;
      lead = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] data);
      case (idx)
        mmpcc_pkg::CFG_COLOR_MODE:    mode = data[2:0];
        mmpcc_pkg::CFG_PRECISION_A:   prec[0] = data[4:0];
        mmpcc_pkg::CFG_PRECISION_B:   prec[1] = data[4:0];
        mmpcc_pkg::CFG_PRECISION_C:   prec[2] = data[4:0];
        mmpcc_pkg::CFG_PRECISION_D:   prec[3] = data[4:0];
        mmpcc_pkg::CFG_CHROMA_SIGNED: signed_mask = data[1:0];
        mmpcc_pkg::CFG_ALPHA_LEADING: lead = data[0];
        default: ;
      endcase
    endfunction

    function int used_bits(int p);
      if (p < 1) return 1;
      if (p > mmpcc_pkg::SAMPLE_BITS) return mmpcc_pkg::SAMPLE_BITS;
      return p;
    endfunction

    function longint gain(int p);
      longint m;
      m = (64'sd1 <<< p) - 1;
      return (64'sd255 * 65536 + m - 1) / m;
    endfunction

    function logic [7:0] sat8(longint v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
    endfunction

    function logic [7:0] ink(longint x, longint k);
      longint lim, ax, ak;
      lim = 64'sd255 * 255 * (64'sd1 <<< 32);
      if (x == 0 || k == 0) return 8'd0;
      if ((x < 0) != (k < 0)) return 8'd0;
      ax = x < 0 ? -x : x;
      ak = k < 0 ? -k : k;
      if (ax > lim / ak) return 8'd255;
      return sat8((ax * ak) / (64'sd255 * (64'sd1 <<< 32)));
    endfunction

    // work out the colour for one accepted input transaction
    function void note_input(logic [15:0] sa_in, logic signed [16:0] sb_in,
                             logic signed [16:0] sc_in, logic [15:0] sd_in);
      int     pa, pb, pc, pd;
      longint ga, gb, gc, gd, a, b, c, d, yf, cbf, crf, cb, cr, kk, q16, q32;
      pixel_t px;
      pa = used_bits(prec[0]); pb = used_bits(prec[1]);
      pc = used_bits(prec[2]); pd = used_bits(prec[3]);
      ga = gain(pa); gb = gain(pb); gc = gain(pc); gd = gain(pd);
      a = sa_in; b = sb_in; c = sc_in; d = sd_in;
      q16 = 64'sd65536;
      q32 = 64'sd1 <<< 32;
      px = '{8'd0, 8'd0, 8'd0, 8'd255};
      case (mode)
        mmpcc_pkg::MODE_RGB: begin
          px.red = sat8(a * ga / q16); px.green = sat8(b * gb / q16);
          px.blue = sat8(c * gc / q16);
        end
        mmpcc_pkg::MODE_RGBA: begin
          if (lead) begin
            px.alpha = sat8(a * ga / q16); px.red = sat8(b * gb / q16);
            px.green = sat8(c * gc / q16); px.blue = sat8(d * gd / q16);
          end else begin
            px.red = sat8(a * ga / q16); px.green = sat8(b * gb / q16);
            px.blue = sat8(c * gc / q16); px.alpha = sat8(d * gd / q16);
          end
        end
        mmpcc_pkg::MODE_GRAY: begin
          px.red = sat8(a * ga / q16);
          px.green = px.red; px.blue = px.red;
        end
        mmpcc_pkg::MODE_GRAYA: begin
          if (lead) begin
            px.red = sat8(b * gb / q16); px.alpha = sat8(a * ga / q16);
          end else begin
            px.red = sat8(a * ga / q16); px.alpha = sat8(b * gb / q16);
          end
          px.green = px.red; px.blue = px.red;
        end
        mmpcc_pkg::MODE_SYCC: begin
          yf = a * ga;
          cbf = (b - (64'sd1 <<< (pb - 1))) * gb;
          crf = (c - (64'sd1 <<< (pc - 1))) * gc;
          px.red = sat8((yf * q16 + 91881 * crf) / q32);
          px.green = sat8((yf * q16 - (22544 * cbf + 46793 * crf)) / q32);
          px.blue = sat8((yf * q16 + 116130 * cbf) / q32);
        end
        mmpcc_pkg::MODE_EYCC: begin
          cb = b; cr = c;
          if (!signed_mask[0]) cb -= 64'sd1 <<< (pa - 1);
          if (!signed_mask[1]) cr -= 64'sd1 <<< (pa - 1);
          px.red = sat8((a * q16 - 2 * cb + 91881 * cr + 32768) * ga / q32);
          px.green = sat8((65556 * a - 22553 * cb - 46800 * cr + 32768) * ga / q32);
          px.blue = sat8((65524 * a + 116132 * cb - cr + 32768) * ga / q32);
        end
        mmpcc_pkg::MODE_CMYK: begin
          kk = 255 * q16 - d * gd;
          px.red = ink(255 * q16 - a * ga, kk);
          px.green = ink(255 * q16 - b * gb, kk);
          px.blue = ink(255 * q16 - c * gc, kk);
        end
        default: ;
      endcase
      pending.push_back(px);
    endfunction

    function void check_output(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transaction %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.alpha !== want.alpha) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: expected r%0d g%0d b%0d a%0d, got r%0d g%0d b%0d a%0d",
                   want.red, want.green, want.blue, want.alpha,
                   got.red, got.green, got.blue, got.alpha);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [15:0]        sample_a_i = '0;
  logic signed [16:0] sample_b_i = '0;
  logic signed [16:0] sample_c_i = '0;
  logic [15:0]        sample_d_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [7:0]         red_o, green_o, blue_o, alpha_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [7:0]         cfg_data_i = '0;

  pixel_scoreboard colours = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  logic [4:0] cur_prec [4];

  multi_mode_pixel_color_converter_core u_top (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    if (rst_ni && out_valid_o && out_ready_i)
      colours.check_output('{red_o, green_o, blue_o, alpha_o});
  end

  task automatic send_pixel(logic [15:0] a, logic signed [16:0] b,
                            logic signed [16:0] c, logic [15:0] d);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    sample_a_i <= a; sample_b_i <= b; sample_c_i <= c; sample_d_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    colours.note_input(a, b, c, d);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (colours.pending.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    colours.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup(logic [2:0] mode, logic [4:0] pa, logic [4:0] pb,
                       logic [4:0] pc, logic [4:0] pd, logic [1:0] mask, logic lead);
    drain();
    write_reg(mmpcc_pkg::CFG_COLOR_MODE, {5'd0, mode});
    write_reg(mmpcc_pkg::CFG_PRECISION_A, {3'd0, pa});
    write_reg(mmpcc_pkg::CFG_PRECISION_B, {3'd0, pb});
    write_reg(mmpcc_pkg::CFG_PRECISION_C, {3'd0, pc});
    write_reg(mmpcc_pkg::CFG_PRECISION_D, {3'd0, pd});
    write_reg(mmpcc_pkg::CFG_CHROMA_SIGNED, {6'd0, mask});
    write_reg(mmpcc_pkg::CFG_ALPHA_LEADING, {7'd0, lead});
    cur_prec = '{pa, pb, pc, pd};
  endtask

  function automatic logic [4:0] pick_prec();
    case ($urandom_range(0, 7))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(1, 16));
    endcase
  endfunction

  // mostly in range for the precision, sometimes any bit pattern or signed
  function automatic logic [16:0] pick_sample(logic [4:0] p);
    int bits;
    bits = p == 0 ? 1 : (p > 16 ? 16 : p);
    case ($urandom_range(0, 9))
      0: return 17'($urandom);
      1: return -17'($urandom_range(1, 1 << (bits - 1)));
      2: return 17'((1 << bits) - 1);
      3: return 17'd0;
      default: return 17'($urandom_range(0, (1 << bits) - 1));
    endcase
  endfunction

  initial begin
    logic [16:0] sa, sb, sc, sd;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners under reset settings, then each mode including the unused code
    send_pixel(16'd0, 17'sd0, 17'sd0, 16'd0);
    send_pixel(16'd255, 17'sd255, 17'sd255, 16'd255);
    send_pixel(16'hFFFF, 17'sd65535, 17'sd65535, 16'hFFFF);
    send_pixel(16'd128, -17'sd32768, -17'sd1, 16'd1);
    for (int m = 0; m < 8; m++) begin
      setup(3'(m), 5'd8, 5'd8, 5'd8, 5'd8, 2'(m), m[0]);
      send_pixel(16'd200, 17'sd30, 17'sd240, 16'd90);
      send_pixel(16'hFFFF, -17'sd32768, 17'sd65535, 16'd0);
    end
    setup(mmpcc_pkg::MODE_SYCC, 5'd0, 5'd31, 5'd16, 5'd1, 2'd3, 1'b1);
    send_pixel(16'hFFFF, 17'sd0, 17'sd65535, 16'd1);
    setup(mmpcc_pkg::MODE_CMYK, 5'd16, 5'd16, 5'd16, 5'd16, 2'd0, 1'b0);
    send_pixel(16'd0, 17'sd0, -17'sd100, 16'd0);

    for (int seg = 0; seg < 35; seg++) begin
      case (seg % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 57; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 57; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      setup(($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, 6)),
            pick_prec(), pick_prec(), pick_prec(), pick_prec(),
            2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      for (int i = 0; i < 50; i++) begin
        sa = pick_sample(cur_prec[0]);
        sb = pick_sample(cur_prec[1]);
        sc = pick_sample(cur_prec[2]);
        sd = pick_sample(cur_prec[3]);
        send_pixel(sa[15:0], sb, sc, sd[15:0]);
      end
    end

    in_valid_i <= 1'b0;
    while (colours.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (colours.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- multi_mode_pixel_color_converter_core.f -----
src/mmpcc_pkg.sv
src/mmpcc_cmyk.sv
src/multi_mode_pixel_color_converter_core.sv
bench/multi_mode_pixel_color_converter_core_test.sv
